// ===== rtl/ifp_pkg.sv =====
// Package with shared constants and the result type of the frame parser.
package ifp_pkg;

  // Framing constants.
  localparam logic [7:0] SYNC_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_LOW    = 8'h50;
  localparam logic [7:0] TYPE_HIGH   = 8'h59;
  localparam int unsigned FRAME_LEN   = 11;
  localparam int unsigned PAYLOAD_LEN = 8;

  // Byte positions inside a frame.
  localparam logic [3:0] POS_HUNT     = 4'd0;
  localparam logic [3:0] POS_TYPE     = 4'd1;
  localparam logic [3:0] POS_CHECKSUM = 4'(FRAME_LEN - 1);

  // Frame status codes.
  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_BAD  = 1'b1;

  // One result item.
  typedef struct packed {
    logic        frame_status;
    logic [3:0]  type_index;
    logic [63:0] payload;
    logic        group_boundary;
  } result_t;

endpackage

// ===== rtl/ifp_deframer.sv =====
// Byte-by-byte frame tracking, checksum check and result generation.
module ifp_deframer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_acc,
  input  logic [7:0]          rx_byte,
  output logic                res_valid,
  output ifp_pkg::result_t    res
);

  logic [3:0]  pos_r, pos_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [3:0]  type_r, type_nxt;
  logic [63:0] payload_r, payload_nxt;
  logic [3:0]  prev_r, prev_nxt;
  logic        good;
  logic        type_ok;

  assign type_ok = (rx_byte >= ifp_pkg::TYPE_LOW) && (rx_byte <= ifp_pkg::TYPE_HIGH);
  assign good    = (rx_byte == sum_r);

  // Next-state logic for one accepted byte.
  always_comb begin
    pos_nxt     = pos_r;
    sum_nxt     = sum_r;
    type_nxt    = type_r;
    payload_nxt = payload_r;
    prev_nxt    = prev_r;
    res_valid   = 1'b0;
    res         = '0;
    if (byte_acc) begin
      if (pos_r == ifp_pkg::POS_HUNT || pos_r > ifp_pkg::POS_CHECKSUM) begin
        pos_nxt = ifp_pkg::POS_HUNT;
        if (rx_byte == ifp_pkg::SYNC_BYTE) begin
          sum_nxt     = rx_byte;
          payload_nxt = '0;
          pos_nxt     = ifp_pkg::POS_TYPE;
        end
      end else if (pos_r == ifp_pkg::POS_TYPE) begin
        if (type_ok) begin
          type_nxt = rx_byte[3:0];
          sum_nxt  = sum_r + rx_byte;
          pos_nxt  = pos_r + 4'd1;
        end else begin
          pos_nxt = ifp_pkg::POS_HUNT;
        end
      end else if (pos_r < ifp_pkg::POS_CHECKSUM) begin
        // Payload bytes enter from the top so the first one ends in bits 7:0.
        payload_nxt = {rx_byte, payload_r[63:8]};
        sum_nxt     = sum_r + rx_byte;
        pos_nxt     = pos_r + 4'd1;
      end else begin
        // Checksum byte closes the frame and emits one result item.
        res_valid          = 1'b1;
        res.frame_status   = good ? ifp_pkg::STATUS_GOOD : ifp_pkg::STATUS_BAD;
        res.type_index     = type_r;
        res.payload        = good ? payload_r : 64'd0;
        res.group_boundary = good && (type_r < prev_r);
        if (good) begin
          prev_nxt = type_r;
        end
        pos_nxt = ifp_pkg::POS_HUNT;
      end
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= ifp_pkg::POS_HUNT;
      sum_r  <= '0;
      type_r <= '0;
      prev_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      type_r <= type_nxt;
      prev_r <= prev_nxt;
    end
  end

  // The payload shifter needs no reset; a sync byte clears it.
  always_ff @(posedge clk) begin
    payload_r <= payload_nxt;
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= ifp_pkg::POS_CHECKSUM)
    else $error("byte position out of range");

  a_res_on_checksum: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (byte_acc && pos_r == ifp_pkg::POS_CHECKSUM))
    else $error("result raised outside the checksum byte");

  a_prev_update: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.frame_status == ifp_pkg::STATUS_GOOD) |=> (prev_r == $past(type_r)))
    else $error("previous good type not updated");
`endif

endmodule

// ===== rtl/ifp_out_stage.sv =====
// Result register with a skid entry that takes one more result under stall before full is raised.
module ifp_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  input  ifp_pkg::result_t res,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output ifp_pkg::result_t out_res
);

  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  ifp_pkg::result_t out_data_r, out_data_nxt;
  ifp_pkg::result_t skid_data_r, skid_data_nxt;
  logic             pop;

  assign pop       = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_data_r;

  // Move items between the skid entry and the output register.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || pop) begin
        out_data_nxt  = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Valid flags reset; data registers do not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds an item while the output register is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !skid_valid_r)
    else $error("result pushed into a full output stage");

  a_bad_frame_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.frame_status == ifp_pkg::STATUS_BAD) |->
      (out_data_r.payload == 64'd0 && !out_data_r.group_boundary))
    else $error("bad frame carries payload or boundary flag");
`endif

endmodule

// ===== rtl/imu_serial_frame_parser_unit.sv =====
// Top level of the serial frame parser.
//
// The input channel takes one received byte per item on in_rx_byte, qualified
// by in_valid and in_stall. Bytes are scanned for 11-byte frames: sync 0x55,
// a type byte 0x50..0x59, eight payload bytes and an additive checksum byte.
// The result channel gives one item per completed frame: out_frame_status,
// out_type_index, out_payload and out_group_boundary.
// Throughput is one byte per cycle while in_stall is low; every byte is
// handled by the frame-state registers in the cycle it is accepted. The result
// of a frame is registered in the output register, or in the skid entry on stall.
// Reset (rst_n low, synchronous) returns the parser to sync hunting, clears
// the last good type and empties the output stage.
// When the receiver stalls, the output register holds its item and a second
// item may be captured in a skid entry; in_stall rises only while that skid
// entry is occupied, and drops the cycle after the receiver takes an item.
module imu_serial_frame_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_frame_status,
  output logic [3:0]  out_type_index,
  output logic [63:0] out_payload,
  output logic        out_group_boundary
);

  logic             byte_acc;
  logic             res_valid;
  logic             full;
  ifp_pkg::result_t res;
  ifp_pkg::result_t out_res;

  assign in_stall = full;
  assign byte_acc = in_valid && !full;

  ifp_deframer u_deframer (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_acc  (byte_acc),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  ifp_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_frame_status   = out_res.frame_status;
  assign out_type_index     = out_res.type_index;
  assign out_payload        = out_res.payload;
  assign out_group_boundary = out_res.group_boundary;

endmodule
